// ===== rtl/core/double_normal_selectivity_top_assert.svh =====
// assertion helpers shared by the rtl modules
`ifndef DOUBLE_NORMAL_SELECTIVITY_TOP_ASSERT_SVH
`define DOUBLE_NORMAL_SELECTIVITY_TOP_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define DNS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dns_pkg.sv =====
package dns_pkg;

  localparam int REG_W    = 16;
  localparam int S_W      = 22;   // scaled distance below the flush limit, Q2.20
  localparam int N_W      = 4;    // integer part of the exponent
  localparam int F_W      = 40;   // fraction of the exponent
  localparam int X_W      = N_W + F_W;
  localparam int TBL_W    = 31;   // table entries are at most 1.0 in Q1.30
  localparam int PROD_W   = REG_W + TBL_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int Q30_SH   = 30;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int TAYLOR_TERMS = 20;

  localparam logic [REG_W-1:0] PEAK_AGE_RST    = 16'd0;
  localparam logic [REG_W-1:0] INV_WIDTH_RST   = 16'd4096;
  localparam logic [REG_W-1:0] PEAK_HEIGHT_RST = 16'd32768;
  localparam logic [REG_W-1:0] SEL_MAX         = 16'hFFFF;

  localparam int CFG_IDX_W = 4;
  localparam int QDEPTH    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_AGE    = 4'd0,
    REG_INV_LEFT    = 4'd1,
    REG_INV_RIGHT   = 4'd2,
    REG_PEAK_HEIGHT = 4'd3
  } dns_reg_t;

  typedef struct packed {
    logic [REG_W-1:0] peak_age;
    logic [REG_W-1:0] inv_left;
    logic [REG_W-1:0] inv_right;
    logic [REG_W-1:0] peak_height;
  } dns_cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic           flush;
    logic [S_W-1:0] s;
  } dns_item_t;

  // exp(-y), y in Q.30 below 1.0, result Q.30, integer taylor series
  function automatic logic [63:0] neg_exp_q30(input logic [63:0] y);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = ONE_Q30;
    neg  = 64'd0;
    term = ONE_Q30;
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = (term * y) >> 30;
      term = term / 64'(i);
      if (i % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    if (neg >= pos) begin
      return 64'd0;
    end
    pos = pos - neg;
    if (pos > ONE_Q30) begin
      pos = ONE_Q30;
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/dns_front.sv =====
module dns_front
  import dns_pkg::*;
#(
  parameter int AGE_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dns_cfg_t             cfg,
  input  logic                 age_valid,
  output logic                 age_ready,
  input  logic [AGE_WIDTH-1:0] age,
  output logic                 item_valid,
  input  logic                 item_ready,
  output dns_item_t            item
);

  localparam int AQ_W = AGE_WIDTH + 8;
  localparam int D_W  = (AQ_W > REG_W) ? AQ_W : REG_W;
  localparam int SP_W = D_W + REG_W;

  logic             v0_r, v1_r;
  logic [D_W-1:0]   d_r, d_nxt;
  logic [REG_W-1:0] inv_r, inv_nxt;
  logic [SP_W-1:0]  s_r;
  logic             f0_ready, f1_ready;
  logic [D_W-1:0]   age_q8;
  logic [D_W-1:0]   mu;

  assign age_q8 = D_W'({age, 8'd0});
  assign mu     = D_W'(cfg.peak_age);

  // age equal to mu takes the right side
  always_comb begin
    if (age_q8 < mu) begin
      d_nxt   = mu - age_q8;
      inv_nxt = cfg.inv_left;
    end else begin
      d_nxt   = age_q8 - mu;
      inv_nxt = cfg.inv_right;
    end
  end

  assign f1_ready  = !v1_r || item_ready;
  assign f0_ready  = !v0_r || f1_ready;
  assign age_ready = f0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (f0_ready) begin
        v0_r <= age_valid;
      end
      if (f1_ready) begin
        v1_r <= v0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f0_ready) begin
      d_r   <= d_nxt;
      inv_r <= inv_nxt;
    end
    if (f1_ready) begin
      s_r <= SP_W'(d_r) * SP_W'(inv_r);
    end
  end

  // scaled distance of 4.0 or more means exponent of 16 or more
  assign item_valid = v1_r;
  assign item.flush = |s_r[SP_W-1:S_W];
  assign item.s     = s_r[S_W-1:0];

endmodule

// ===== rtl/core/dns_queue.sv =====
module dns_queue
  import dns_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  dns_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output dns_item_t pop_item
);

  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam int IDX_W = $clog2(QDEPTH);

  dns_item_t        ent_r   [QDEPTH];
  dns_item_t        ent_nxt [QDEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;
  logic [CNT_W-1:0] wr_pos;

  assign push_ready = count_r < CNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = ent_r[0];

  // head always sits in entry 0, the rest shift down on a pop
  assign wr_pos = pop ? (count_r - CNT_W'(1)) : count_r;

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if (pop && i < QDEPTH - 1) begin
        ent_nxt[i] = ent_r[(i + 1) % QDEPTH];
      end
      if (push && wr_pos[IDX_W-1:0] == IDX_W'(i)) begin
        ent_nxt[i] = push_item;
      end
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

`include "double_normal_selectivity_top_assert.svh"

  `DNS_ASSERT_ALWAYS(a_q_bound, count_r <= CNT_W'(QDEPTH), "queue count past depth")
  `DNS_ASSERT_NEXT(a_q_grow, push && !pop, count_r == $past(count_r) + CNT_W'(1), "queue count did not grow")
  `DNS_ASSERT_NEXT(a_q_shrink, pop && !push, count_r == $past(count_r) - CNT_W'(1), "queue count did not shrink")

endmodule

// ===== rtl/core/dns_back.sv =====
module dns_back
  import dns_pkg::*;
#(
  parameter int EXP2_TABLE_ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dns_cfg_t         cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  dns_item_t        item,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [REG_W-1:0] res
);

  localparam int IDX_W  = $clog2(EXP2_TABLE_ENTRIES);
  localparam int NC_W   = IDX_W + 1;
  localparam int FN_W   = F_W + NC_W;
  localparam logic [NC_W-1:0] NC = NC_W'(EXP2_TABLE_ENTRIES);

  logic [TBL_W-1:0] tbl [EXP2_TABLE_ENTRIES];

  // 2^(-k/N) in Q1.30, worked out at elaboration
  for (genvar k = 0; k < EXP2_TABLE_ENTRIES; k++) begin : g_tbl
    localparam logic [63:0] Y = (64'(k) * LN2_Q30) / EXP2_TABLE_ENTRIES;
    localparam logic [63:0] ENT = neg_exp_q30(Y);
    assign tbl[k] = ENT[TBL_W-1:0];
  end

  logic              v1_r, v2_r, v3_r, v4_r;
  logic              r1, r2, r3, r4;
  logic              fl1_r, fl2_r, fl3_r;
  logic [X_W-1:0]    x_r;
  logic [N_W-1:0]    n2_r, n3_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PROD_W-1:0] prod_r;
  logic [REG_W-1:0]  res_r, res_nxt;
  logic [FN_W-1:0]   fn;
  logic [SUM_W-1:0]  rnd, sum, shifted;

  assign r4 = !v4_r || res_ready;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign item_ready = r1;

  assign fn = FN_W'(x_r[F_W-1:0]) * FN_W'(NC);

  // round half up at bit 30+n, then zero flushed items or saturate
  always_comb begin
    rnd     = SUM_W'(1) << (SUM_W'(Q30_SH - 1) + SUM_W'(n3_r));
    sum     = SUM_W'(prod_r) + rnd;
    shifted = sum >> (SUM_W'(Q30_SH) + SUM_W'(n3_r));
    if (fl3_r) begin
      res_nxt = '0;
    end else if (|shifted[SUM_W-1:REG_W]) begin
      res_nxt = SEL_MAX;
    end else begin
      res_nxt = shifted[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (r1) v1_r <= item_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      x_r   <= X_W'(item.s) * X_W'(item.s);
      fl1_r <= item.flush;
    end
    if (r2) begin
      n2_r  <= x_r[X_W-1:F_W];
      idx_r <= fn[F_W +: IDX_W];
      fl2_r <= fl1_r;
    end
    if (r3) begin
      prod_r <= PROD_W'(cfg.peak_height) * PROD_W'(tbl[idx_r]);
      n3_r   <= n2_r;
      fl3_r  <= fl2_r;
    end
    if (r4) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = v4_r;
  assign res       = res_r;

`include "double_normal_selectivity_top_assert.svh"

  `DNS_ASSERT_ALWAYS(a_idx_range, !v2_r || (32'(idx_r) < EXP2_TABLE_ENTRIES), "table index out of range")
  `DNS_ASSERT_NEXT(a_flush_zero, v3_r && r4 && fl3_r, res_r == '0, "flushed item gave nonzero result")
  `DNS_ASSERT_NEXT(a_zero_alpha, v3_r && r4 && cfg.peak_height == '0, res_r == '0, "zero alpha gave nonzero result")

endmodule

// ===== rtl/core/double_normal_selectivity_top.sv =====
// channel  | ports                      | payload
// in       | in_tvalid/in_tready        | in_tdata: age
// out      | out_tvalid/out_tready      | out_tdata: selectivity, Q1.15
// cfg      | cfg_wr_en/cfg_index        | cfg_wdata: register value
//
// one item per cycle sustained while out_tready stays high
// a beat passes 2 front stages (distance, scaling multiply), the queue register
// and 4 back stages (square, table index, alpha multiply, round and shift)
// rst_n clears all valid bits and the queue and loads register reset values
// out_tready low stalls the back stages; the 4-entry queue then fills before in_tready drops
module double_normal_selectivity_top
  import dns_pkg::*;
#(
  parameter int AGE_WIDTH          = 8,
  parameter int EXP2_TABLE_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((AGE_WIDTH + 7) / 8) * 8-1:0] in_tdata,   // [AGE_WIDTH-1:0] age
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [REG_W-1:0]                    out_tdata,  // [15:0] selectivity
  input  logic                                cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [REG_W-1:0]                    cfg_wdata
);

  dns_cfg_t  cfg_r;
  dns_item_t f_item, q_item;
  logic      f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_age    <= PEAK_AGE_RST;
      cfg_r.inv_left    <= INV_WIDTH_RST;
      cfg_r.inv_right   <= INV_WIDTH_RST;
      cfg_r.peak_height <= PEAK_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (dns_reg_t'(cfg_index))
        REG_PEAK_AGE:    cfg_r.peak_age    <= cfg_wdata;
        REG_INV_LEFT:    cfg_r.inv_left    <= cfg_wdata;
        REG_INV_RIGHT:   cfg_r.inv_right   <= cfg_wdata;
        REG_PEAK_HEIGHT: cfg_r.peak_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dns_front #(
    .AGE_WIDTH(AGE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .age_valid  (in_tvalid),
    .age_ready  (in_tready),
    .age        (in_tdata[AGE_WIDTH-1:0]),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  dns_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  dns_back #(
    .EXP2_TABLE_ENTRIES(EXP2_TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (out_tdata)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dns_pkg::*;

  localparam int AGE_W        = 8;
  localparam int TABLE_N      = 64;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_GAP    = 12;
  localparam int MAX_CYCLES   = 300000;
  localparam int SHOW_MAX     = 10;
  localparam int SETS_PER_RUN = 4;
  localparam int AGES_PER_SET = 67;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd9;

  typedef struct {
    logic [AGE_W-1:0] age;
    logic [REG_W-1:0] sel;
  } sel_expect_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [AGE_W-1:0]     in_tdata   = '0;   // [7:0] age
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [REG_W-1:0]     out_tdata;         // [15:0] selectivity
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [REG_W-1:0]     cfg_wdata  = '0;

  // register mirror
  logic [REG_W-1:0] mu_r;
  logic [REG_W-1:0] inv_l_r;
  logic [REG_W-1:0] inv_r_r;
  logic [REG_W-1:0] alpha_r;

  logic [63:0]  pow2_frac_q30 [TABLE_N];
  sel_expect_t  sel_expect_q [$];
  sel_expect_t  head;
  int           send_idle_pct = 20;
  int           recv_idle_pct = 48;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  double_normal_selectivity_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // exp(-y) by alternating series, y and result in Q.30
  function automatic logic [63:0] series_neg_exp(input logic [63:0] y);
    logic [63:0] even_sum;
    logic [63:0] odd_sum;
    logic [63:0] term;
    even_sum = ONE_Q30;
    odd_sum  = 64'd0;
    term     = ONE_Q30;
    for (int k = 1; k <= 20; k++) begin
      term = (term * y) >> 30;
      term = term / 64'(k);
      if (k % 2 == 1) begin
        odd_sum = odd_sum + term;
      end else begin
        even_sum = even_sum + term;
      end
    end
    if (odd_sum >= even_sum) begin
      return 64'd0;
    end
    even_sum = even_sum - odd_sum;
    return (even_sum > ONE_Q30) ? ONE_Q30 : even_sum;
  endfunction

  function automatic logic [REG_W-1:0] predict_selectivity(input logic [AGE_W-1:0] age);
    logic [REG_W-1:0] age_fix;
    logic [REG_W-1:0] dist_q8;
    logic [REG_W-1:0] inv;
    logic [31:0]      scaled;
    logic [63:0]      expo;
    logic [63:0]      prod;
    logic [63:0]      rounded;
    int               idx;
    int               shift;
    age_fix = {age, 8'd0};
    if (age_fix < mu_r) begin
      dist_q8 = mu_r - age_fix;
      inv     = inv_l_r;
    end else begin
      dist_q8 = age_fix - mu_r;
      inv     = inv_r_r;
    end
    scaled = dist_q8 * inv;
    // exponent of 16 or more flushes to zero
    if (scaled >= (32'd4 << 20)) begin
      return '0;
    end
    expo = 64'(scaled) * 64'(scaled);
    idx  = int'((64'(expo[39:0]) * 64'(TABLE_N)) >> 40);
    if (idx >= TABLE_N) begin
      idx = TABLE_N - 1;
    end
    shift   = 30 + int'(expo[47:40]);
    prod    = 64'(alpha_r) * pow2_frac_q30[idx];
    rounded = (prod + (64'd1 << (shift - 1))) >> shift;
    return (rounded > 64'(SEL_MAX)) ? SEL_MAX : rounded[REG_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [AGE_W-1:0] age,
                                 input logic [REG_W-1:0] exp_sel,
                                 input logic [REG_W-1:0] act_sel);
    mismatch_count++;
    if (mismatch_count <= SHOW_MAX) begin
      $display("%0t: %s age=%0d expected=%0d actual=%0d", $realtime, what, age, exp_sel,
               act_sel);
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sel_expect_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, '0, out_tdata);
      end else begin
        head = sel_expect_q.pop_front();
        if (out_tdata !== head.sel) begin
          report_mismatch("selectivity mismatch", head.age, head.sel, out_tdata);
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_age(input logic [AGE_W-1:0] age);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= age;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sel_expect_q.push_back('{age: age, sel: predict_selectivity(age)});
  endtask

  // hold input off until every expected beat is back, then let the pipe settle
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (sel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PEAK_AGE:    mu_r    = value;
      REG_INV_LEFT:    inv_l_r = value;
      REG_INV_RIGHT:   inv_r_r = value;
      REG_PEAK_HEIGHT: alpha_r = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [REG_W-1:0] mu, input logic [REG_W-1:0] inv_l,
                                input logic [REG_W-1:0] inv_r, input logic [REG_W-1:0] alpha);
    drain_pipeline();
    write_reg(REG_PEAK_AGE, mu);
    write_reg(REG_INV_LEFT, inv_l);
    write_reg(REG_INV_RIGHT, inv_r);
    write_reg(REG_PEAK_HEIGHT, alpha);
  endtask

  task automatic test_reset_state();
    send_age(8'd0);
    send_age(8'd1);
    send_age(8'd2);
    send_age(8'd4);
    send_age(8'd255);
  endtask

  task automatic test_extreme_config();
    apply_settings(16'h8080, 16'd1, 16'hFFFF, 16'hFFFF);
    send_age(8'd0);
    send_age(8'd128);
    send_age(8'd129);
    send_age(8'd255);
  endtask

  task automatic test_peak_and_flush_edge();
    apply_settings(16'h4000, 16'd4096, 16'd4096, 16'd32768);
    send_age(8'd64);
    send_age(8'd63);
    // scaled distance just under the flush limit
    apply_settings(16'h0000, 16'd4096, 16'd4095, 16'hFFFF);
    send_age(8'd4);
    send_age(8'd3);
  endtask

  task automatic test_zero_width();
    apply_settings(16'h8000, 16'd0, 16'd0, 16'd40000);
    send_age(8'd0);
    send_age(8'd255);
  endtask

  task automatic test_zero_alpha();
    drain_pipeline();
    write_reg(REG_PEAK_HEIGHT, 16'd0);
    send_age(8'd128);
    send_age(8'd100);
  endtask

  task automatic test_unmapped_index();
    apply_settings(16'h5A40, 16'd900, 16'd1500, 16'd50000);
    write_reg(REG_UNMAPPED, 16'h1234);
    send_age(8'd90);
    send_age(8'd77);
  endtask

  function automatic logic [REG_W-1:0] random_inv_width();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(256, 2048));
      2:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(2048, 16384));
    endcase
  endfunction

  task automatic test_random_stream(input int send_pct, input int recv_pct, input int extreme);
    int off;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int set = 0; set < SETS_PER_RUN; set++) begin
      if (set == 0 && extreme == 0) begin
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      end else if (set == 0 && extreme == 1) begin
        apply_settings(16'h0000, 16'd1, 16'd1, 16'd1);
      end else if (set == 0) begin
        apply_settings(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
      end else begin
        apply_settings(16'($urandom_range(0, 65535)), random_inv_width(), random_inv_width(),
                       16'($urandom_range(1, 65535)));
      end
      for (int n = 0; n < AGES_PER_SET; n++) begin
        // mostly ages within 8 of the peak, the rest anywhere in range
        if ($urandom_range(0, 9) < 7) begin
          off = int'($urandom_range(0, 16)) - 8;
          send_age(AGE_W'(int'(mu_r[15:8]) + off));
        end else begin
          send_age(AGE_W'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < TABLE_N; k++) begin
      pow2_frac_q30[k] = series_neg_exp((64'(k) * LN2_Q30) / 64'(TABLE_N));
    end
    mu_r    = PEAK_AGE_RST;
    inv_l_r = INV_WIDTH_RST;
    inv_r_r = INV_WIDTH_RST;
    alpha_r = PEAK_HEIGHT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extreme_config();
    test_peak_and_flush_edge();
    test_zero_width();
    test_zero_alpha();
    test_unmapped_index();
    test_random_stream(20, 48, 0);
    test_random_stream(48, 20, 1);
    test_random_stream(0, 0, 2);

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
